// ===== design/bskl_pkg.sv =====
// shared types and constants of the bucketed sorted key lookup block
package bskl_pkg;

	localparam int KEY_W           = 64;
	localparam int CNT_W           = 32;
	localparam int SHIFT_W         = 6;
	localparam int MIN_FILL_FACTOR = 8;
	localparam int ENTRY_W         = KEY_W + CNT_W;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_BUILD  = 2'd2,
		CMD_LOOKUP = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} stat_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [KEY_W-1:0]   key;
		logic [CNT_W-1:0]   entry_count_value;
	} req_word_t;

	typedef struct packed {
		stat_t              status;
		logic [CNT_W-1:0]   found_count;
	} rsp_word_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_EXEC,
		ST_B_FIRST,
		ST_B_LAST,
		ST_B_SHIFT,
		ST_B_RD,
		ST_B_DIFF,
		ST_B_BKT,
		ST_B_FILL,
		ST_B_TAIL,
		ST_L_BKT,
		ST_L_LO,
		ST_L_HI,
		ST_L_RANGE,
		ST_S_A,
		ST_S_B,
		ST_S_MID,
		ST_S_CMP,
		ST_RESP
	} state_t;

endpackage

// ===== design/bskl_ram.sv =====
// simple dual port synchronous ram, one write and one registered read per cycle
module bskl_ram
	import bskl_pkg::*;
#(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16384
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered output
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/bucketed_sorted_key_lookup_top.sv =====
// top level of the bucketed sorted key lookup: command sequencer, table and bucket index
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+---------------------------------------
//  req     | in        | req_valid/req_stall| cmd, key, entry_count_value
//  rsp     | out       | rsp_valid/rsp_stall| status, found_count
//
// One command at a time, one rsp word each; clear, load and a small-table build pass through
// the exec and resp states to the output register, and the next req word is taken in idle after that.
// Lookup: bucket bound reads, then the slice's end entries decide, else one table read per probe
// (single table read port) while bisecting; without an index it skips the bucket states.
// Build: first and last keys, shift search, then a walk over the table filling bucket bounds.
// arst_n clears control state, not the rams; a stalled rsp word waits while the next runs.
module bucketed_sorted_key_lookup_top
	import bskl_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16384,
	parameter int BUCKET_BITS   = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_word_t  req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_word_t  rsp
);

	localparam int BUCKETS = 1 << BUCKET_BITS;
	localparam int AW      = $clog2(TABLE_ENTRIES);
	localparam int FW      = $clog2(TABLE_ENTRIES + 1);
	localparam int BIW     = BUCKET_BITS + 1;
	localparam logic [KEY_W-1:0] MIN_FILL = KEY_W'(MIN_FILL_FACTOR) << BUCKET_BITS;
	localparam logic [FW-1:0]    FILL_MAX = FW'(TABLE_ENTRIES);
	localparam logic [BIW-1:0]   BKT_END  = BIW'(BUCKETS);

	// control state
	state_t                 state_q, state_d;
	logic [FW-1:0]          fill_q;
	logic                   index_valid_q;
	logic [SHIFT_W-1:0]     shift_q;
	logic [BUCKET_BITS-1:0] last_q;
	logic [FW-1:0]          idx_q;
	logic [BIW-1:0]         j_q;
	logic                   rsp_valid_q;

	// payload registers
	req_word_t              req_q;
	logic [KEY_W-1:0]       first_q;
	logic [KEY_W-1:0]       range_q;
	logic [KEY_W-1:0]       diff_q;
	logic [BUCKET_BITS-1:0] h_q;
	logic [BUCKET_BITS-1:0] hb_q;
	logic [FW-1:0]          lo_q;
	logic [FW-1:0]          hi_q;
	logic [AW-1:0]          a_q;
	logic [AW-1:0]          b_q;
	logic [AW-1:0]          mid_q;
	logic [KEY_W-1:0]       ka_q;
	logic [CNT_W-1:0]       cnt_a_q;
	stat_t                  res_status_q;
	logic [CNT_W-1:0]       res_count_q;
	rsp_word_t              rsp_q;

	// ram ports
	logic                   tbl_we, tbl_re;
	logic [AW-1:0]          tbl_waddr, tbl_raddr;
	logic [ENTRY_W-1:0]     tbl_wdata, tbl_rdata;
	logic                   bnd_we, bnd_re;
	logic [BIW-1:0]         bnd_waddr, bnd_raddr;
	logic [FW-1:0]          bnd_wdata, bnd_rdata;

	// helper terms
	logic [KEY_W-1:0]       tbl_rkey;
	logic [CNT_W-1:0]       tbl_rcnt;
	logic [KEY_W-1:0]       bkt_full;
	logic                   bkt_over;
	logic                   range_big;
	logic                   small_tbl;
	logic                   tbl_full;
	logic [FW-1:0]          fill_m1;
	logic [FW-1:0]          hi_clamp;
	logic [FW-1:0]          hi_m1;
	logic                   range_empty;
	logic [AW-1:0]          span;
	logic                   span_gt1;
	logic [AW-1:0]          mid;
	logic                   key_out;
	logic                   hit_a, hit_b;
	logic                   rsp_load;

	assign tbl_rkey    = tbl_rdata[ENTRY_W-1:CNT_W];
	assign tbl_rcnt    = tbl_rdata[CNT_W-1:0];
	assign bkt_full    = diff_q >> shift_q;
	assign bkt_over    = |bkt_full[KEY_W-1:BUCKET_BITS];
	assign range_big   = |range_q[KEY_W-1:BUCKET_BITS];
	assign small_tbl   = !(KEY_W'(fill_q) > MIN_FILL);
	assign tbl_full    = (fill_q == FILL_MAX);
	assign fill_m1     = fill_q - FW'(1);
	assign hi_clamp    = (hi_q > fill_q) ? fill_q : hi_q;
	assign hi_m1       = hi_clamp - FW'(1);
	assign range_empty = (hi_clamp <= lo_q);
	assign span        = b_q - a_q;
	assign span_gt1    = (span > AW'(1));
	assign mid         = a_q + (span >> 1);
	assign key_out     = (req_q.key < ka_q) || (req_q.key > tbl_rkey);
	assign hit_a       = (ka_q == req_q.key);
	assign hit_b       = (tbl_rkey == req_q.key);
	assign rsp_load    = (state_q == ST_RESP) && (!rsp_valid_q || !rsp_stall);

	assign req_stall   = (state_q != ST_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;

	// table of keys and counts
	bskl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// bucket start bounds
	bskl_ram #(
		.WIDTH (FW),
		.DEPTH (BUCKETS + 1)
	) u_bnd (
		.clk   (clk),
		.we    (bnd_we),
		.waddr (bnd_waddr),
		.wdata (bnd_wdata),
		.re    (bnd_re),
		.raddr (bnd_raddr),
		.rdata (bnd_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (req_q.cmd) inside
					CMD_CLEAR, CMD_LOAD: state_d = ST_RESP;
					CMD_BUILD:  state_d = small_tbl ? ST_RESP : ST_B_FIRST;
					CMD_LOOKUP: state_d = index_valid_q ? ST_L_BKT : ST_L_RANGE;
					default:    state_d = ST_RESP;
				endcase
			end
			ST_B_FIRST: state_d = ST_B_LAST;
			ST_B_LAST:  state_d = ST_B_SHIFT;
			ST_B_SHIFT: state_d = range_big ? ST_B_SHIFT : ST_B_RD;
			ST_B_RD:    state_d = (idx_q == fill_q) ? ST_B_TAIL : ST_B_DIFF;
			ST_B_DIFF:  state_d = ST_B_BKT;
			ST_B_BKT:   state_d = ST_B_FILL;
			ST_B_FILL:  state_d = (last_q < h_q) ? ST_B_FILL : ST_B_RD;
			ST_B_TAIL:  state_d = (j_q == BKT_END) ? ST_RESP : ST_B_TAIL;
			ST_L_BKT:   state_d = bkt_over ? ST_RESP : ST_L_LO;
			ST_L_LO:    state_d = ST_L_HI;
			ST_L_HI:    state_d = ST_L_RANGE;
			ST_L_RANGE: state_d = range_empty ? ST_RESP : ST_S_A;
			ST_S_A:     state_d = ST_S_B;
			ST_S_B:     state_d = (key_out || hit_a || hit_b) ? ST_RESP : ST_S_MID;
			ST_S_MID:   state_d = span_gt1 ? ST_S_CMP : ST_RESP;
			ST_S_CMP:   state_d = (tbl_rkey == req_q.key) ? ST_RESP : ST_S_MID;
			ST_RESP: begin
				if (!rsp_valid_q || !rsp_stall) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// ram controls
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = fill_q[AW-1:0];
		tbl_wdata = {req_q.key, req_q.entry_count_value};
		tbl_re    = 1'b0;
		tbl_raddr = '0;
		bnd_we    = 1'b0;
		bnd_waddr = '0;
		bnd_wdata = '0;
		bnd_re    = 1'b0;
		bnd_raddr = {1'b0, hb_q} + BIW'(1);
		unique case (state_q)
			ST_EXEC: begin
				tbl_we = (req_q.cmd == CMD_LOAD) && !tbl_full;
				tbl_re = (req_q.cmd == CMD_BUILD) && !small_tbl;
			end
			ST_B_FIRST: begin
				tbl_re    = 1'b1;
				tbl_raddr = fill_m1[AW-1:0];
			end
			ST_B_SHIFT: begin
				bnd_we = !range_big;
			end
			ST_B_RD: begin
				tbl_re    = (idx_q != fill_q);
				tbl_raddr = idx_q[AW-1:0];
			end
			ST_B_FILL: begin
				bnd_we    = (last_q < h_q);
				bnd_waddr = {1'b0, last_q} + BIW'(1);
				bnd_wdata = idx_q;
			end
			ST_B_TAIL: begin
				bnd_we    = 1'b1;
				bnd_waddr = j_q;
				bnd_wdata = fill_q;
			end
			ST_L_BKT: begin
				bnd_re    = !bkt_over;
				bnd_raddr = {1'b0, bkt_full[BUCKET_BITS-1:0]};
			end
			ST_L_LO: begin
				bnd_re = 1'b1;
			end
			ST_L_RANGE: begin
				tbl_re    = !range_empty;
				tbl_raddr = lo_q[AW-1:0];
			end
			ST_S_A: begin
				tbl_re    = 1'b1;
				tbl_raddr = b_q;
			end
			ST_S_MID: begin
				tbl_re    = span_gt1;
				tbl_raddr = mid;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			fill_q        <= '0;
			index_valid_q <= 1'b0;
			shift_q       <= '0;
			last_q        <= '0;
			idx_q         <= '0;
			j_q           <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_EXEC: begin
					if (req_q.cmd == CMD_CLEAR) begin
						fill_q        <= '0;
						index_valid_q <= 1'b0;
					end else if (req_q.cmd == CMD_LOAD && !tbl_full) begin
						fill_q        <= fill_q + FW'(1);
						index_valid_q <= 1'b0;
					end else if (req_q.cmd == CMD_BUILD) begin
						if (small_tbl) index_valid_q <= 1'b0;
						shift_q <= '0;
					end
				end
				ST_B_SHIFT: begin
					if (range_big) begin
						shift_q <= shift_q + SHIFT_W'(1);
					end else begin
						last_q <= '0;
						idx_q  <= FW'(1);
					end
				end
				ST_B_RD: begin
					j_q <= {1'b0, last_q} + BIW'(1);
				end
				ST_B_FILL: begin
					if (last_q < h_q) begin
						last_q <= last_q + BUCKET_BITS'(1);
					end else begin
						last_q <= h_q;
						idx_q  <= idx_q + FW'(1);
					end
				end
				ST_B_TAIL: begin
					j_q <= j_q + BIW'(1);
					if (j_q == BKT_END) index_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q.status      <= res_status_q;
			rsp_q.found_count <= res_count_q;
		end
		unique case (state_q)
			ST_EXEC: begin
				res_count_q <= '0;
				diff_q      <= req_q.key - first_q;
				lo_q        <= '0;
				hi_q        <= fill_q;
				if (req_q.cmd == CMD_LOOKUP) begin
					res_status_q <= STAT_MISS;
				end else if (req_q.cmd == CMD_LOAD && tbl_full) begin
					res_status_q <= STAT_FULL;
				end else begin
					res_status_q <= STAT_OK;
				end
			end
			ST_B_FIRST: first_q <= tbl_rkey;
			ST_B_LAST:  range_q <= tbl_rkey - first_q;
			ST_B_SHIFT: begin
				if (range_big) range_q <= range_q >> 1;
			end
			ST_B_DIFF:  diff_q <= tbl_rkey - first_q;
			ST_B_BKT: begin
				// bucket numbers past the end saturate to the last bucket
				h_q <= bkt_over ? '1 : bkt_full[BUCKET_BITS-1:0];
			end
			ST_L_BKT:   hb_q <= bkt_full[BUCKET_BITS-1:0];
			ST_L_LO:    lo_q <= bnd_rdata;
			ST_L_HI:    hi_q <= bnd_rdata;
			ST_L_RANGE: begin
				a_q <= lo_q[AW-1:0];
				b_q <= hi_m1[AW-1:0];
			end
			ST_S_A: begin
				ka_q    <= tbl_rkey;
				cnt_a_q <= tbl_rcnt;
			end
			ST_S_B: begin
				// bounds test first, then first entry, then last entry
				if (!key_out && hit_a) begin
					res_status_q <= STAT_OK;
					res_count_q  <= cnt_a_q;
				end else if (!key_out && hit_b) begin
					res_status_q <= STAT_OK;
					res_count_q  <= tbl_rcnt;
				end
			end
			ST_S_MID:   mid_q <= mid;
			ST_S_CMP: begin
				if (tbl_rkey == req_q.key) begin
					res_status_q <= STAT_OK;
					res_count_q  <= tbl_rcnt;
				end else if (req_q.key < tbl_rkey) begin
					b_q <= mid_q;
				end else begin
					a_q <= mid_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== design/bskl_check.sv =====
// port level checks of the bucketed sorted key lookup, bound to the top level
module bskl_check
	import bskl_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input req_word_t  req,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input rsp_word_t  rsp
);

	// a stalled rsp word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp word changed while stalled");

	// one command at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("req accepted back to back");

	// a new rsp word comes only out of the busy phase
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("rsp word without a command in flight");

	// misses and full loads carry a zero count
	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STAT_OK) |-> rsp.found_count == '0)
		else $error("nonzero count on a failed command");

endmodule

bind bucketed_sorted_key_lookup_top bskl_check u_bskl_check (.*);

// ===== sim/tb.sv =====
// testbench for the bucketed sorted key lookup: command stream, table predictor and rsp checker
module tb
	import bskl_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_ENTRIES  = 16384;
	localparam int BKT_BITS       = 10;
	localparam int BUCKETS        = 1 << BKT_BITS;
	localparam int WATCHDOG_LIMIT = 400000;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	bucketed_sorted_key_lookup_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.BUCKET_BITS  (BKT_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// predicted table and bucket index
	logic [KEY_W-1:0] table_keys   [TABLE_ENTRIES];
	logic [CNT_W-1:0] table_counts [TABLE_ENTRIES];
	int unsigned      table_fill;
	int unsigned      bound_of     [BUCKETS+2];
	int unsigned      key_shift;
	bit               index_ok;

	rsp_word_t   owed_rsp [$];
	rsp_word_t   oldest_rsp;
	int          errors;
	int          burst_left;
	int          idle_cycles;
	int          stall_mode;
	int          stall_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// counts lean toward the extremes now and then
	function automatic logic [CNT_W-1:0] rand_count();
		int unsigned sel;
		sel = $urandom_range(0, 15);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return $urandom;
	endfunction

	// search [lo, hi) of the table, first and last entry tested before bisecting
	function automatic bit find_in_slice(int unsigned lo, int unsigned hi,
			logic [KEY_W-1:0] k, output int unsigned pos);
		int unsigned a, b, mid;
		pos = 0;
		if (hi > table_fill)
			hi = table_fill;
		if (hi <= lo)
			return 1'b0;
		a = lo;
		b = hi - 1;
		if (k < table_keys[a] || k > table_keys[b])
			return 1'b0;
		if (table_keys[a] == k) begin
			pos = a;
			return 1'b1;
		end
		if (table_keys[b] == k) begin
			pos = b;
			return 1'b1;
		end
		while (b - a > 1) begin
			mid = a + (b - a) / 2;
			if (table_keys[mid] == k) begin
				pos = mid;
				return 1'b1;
			end
			if (k < table_keys[mid])
				b = mid;
			else
				a = mid;
		end
		return 1'b0;
	endfunction

	// bucket index over the loaded table, only for tables above the fill threshold
	function automatic void build_bucket_index();
		logic [KEY_W-1:0] first_key, key_span, bkt;
		int unsigned i, last, n;
		n = table_fill;
		if (n <= MIN_FILL_FACTOR * BUCKETS) begin
			index_ok = 1'b0;
			return;
		end
		first_key = table_keys[0];
		key_span  = table_keys[n-1] - first_key;
		key_shift = 0;
		while (key_span >= BUCKETS) begin
			key_shift++;
			key_span >>= 1;
		end
		bound_of[0] = 0;
		last = 0;
		for (i = 1; i < n; i++) begin
			bkt = (table_keys[i] - first_key) >> key_shift;
			if (bkt >= BUCKETS)
				bkt = KEY_W'(BUCKETS - 1);
			if (bkt != last) begin
				while (last < bkt) begin
					last++;
					bound_of[last] = i;
				end
				last = bkt[31:0];
			end
		end
		for (i = last + 1; i <= BUCKETS; i++)
			bound_of[i] = n;
		index_ok = 1'b1;
	endfunction

	// rsp word of one command, updating the predicted state
	function automatic rsp_word_t apply_command(req_word_t w);
		rsp_word_t        r;
		int unsigned      lo, hi, pos;
		logic [KEY_W-1:0] bkt;
		r.status      = STAT_OK;
		r.found_count = '0;
		case (w.cmd)
			CMD_CLEAR: begin
				table_fill = 0;
				index_ok   = 1'b0;
			end
			CMD_LOAD: begin
				if (table_fill >= TABLE_ENTRIES) begin
					r.status = STAT_FULL;
				end else begin
					table_keys[table_fill]   = w.key;
					table_counts[table_fill] = w.entry_count_value;
					table_fill++;
					index_ok = 1'b0;
				end
			end
			CMD_BUILD: begin
				build_bucket_index();
			end
			default: begin
				lo = 0;
				hi = table_fill;
				r.status = STAT_MISS;
				if (index_ok) begin
					bkt = (w.key - table_keys[0]) >> key_shift;
					if (bkt >= BUCKETS) begin
						lo = 1;
						hi = 0;
					end else begin
						lo = bound_of[bkt];
						hi = bound_of[bkt+1];
					end
				end
				if (find_in_slice(lo, hi, w.key, pos)) begin
					r.status      = STAT_OK;
					r.found_count = table_counts[pos];
				end
			end
		endcase
		return r;
	endfunction

	// lookup keys: stored keys, their neighbors, keys outside the buckets, noise
	function automatic logic [KEY_W-1:0] pick_probe_key();
		logic [KEY_W-1:0] k;
		int unsigned      sel;
		sel = $urandom_range(0, 9);
		if (table_fill == 0 || sel == 7)
			return rand64();
		k = table_keys[$urandom_range(0, table_fill - 1)];
		case (sel)
			5: k = k + 1;
			6: k = k - 1;
			8: k = table_keys[0] - $urandom_range(1, 1000);
			9: k = table_keys[table_fill-1] + (table_keys[table_fill-1] - table_keys[0])
				+ $urandom_range(1, 4);
			default: ;
		endcase
		return k;
	endfunction

	// send one req word in bursts with random gaps, predict at accept
	task automatic send_word(input cmd_t c, input logic [KEY_W-1:0] k,
			input logic [CNT_W-1:0] v);
		int        gap;
		req_word_t w;
		w.cmd               = c;
		w.key               = k;
		w.entry_count_value = v;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
		end
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		owed_rsp.push_back(apply_command(w));
		burst_left--;
	endtask

	// hold the sender until every rsp word is back
	task automatic wait_for_idle();
		req_valid <= 1'b0;
		burst_left = 0;
		while (owed_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_sorted(int unsigned n, logic [KEY_W-1:0] start, int step_bits,
			int hold_odds);
		logic [KEY_W-1:0] k, key_step;
		k = start;
		repeat (n) begin
			send_word(CMD_LOAD, k, rand_count());
			key_step = rand64() >> (64 - step_bits);
			if ($urandom_range(0, 15) < hold_odds)
				key_step = '0;
			k += key_step;
		end
	endtask

	task automatic probe_lookups(int unsigned n);
		repeat (n)
			send_word(CMD_LOOKUP, pick_probe_key(), rand_count());
	endtask

	task automatic test_empty_table();
		send_word(CMD_LOOKUP, rand64(), rand_count());
		send_word(CMD_BUILD, rand64(), rand_count());
		send_word(CMD_LOOKUP, '0, '0);
	endtask

	// extremes, duplicates, small-table build, unsorted load, clear
	task automatic test_small_table();
		send_word(CMD_LOAD, '0, '0);
		send_word(CMD_LOAD, 64'd5, '1);
		send_word(CMD_LOAD, 64'd5, 32'd7);
		send_word(CMD_LOAD, 64'h8000_0000_0000_0000, 32'h8000_0000);
		send_word(CMD_LOAD, '1, 32'd123);
		send_word(CMD_LOOKUP, '0, rand_count());
		send_word(CMD_LOOKUP, 64'd5, rand_count());
		send_word(CMD_LOOKUP, 64'h8000_0000_0000_0000, rand_count());
		send_word(CMD_LOOKUP, '1, rand_count());
		send_word(CMD_LOOKUP, 64'd3, rand_count());
		send_word(CMD_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, rand_count());
		send_word(CMD_BUILD, rand64(), rand_count());
		send_word(CMD_LOOKUP, 64'd5, rand_count());
		send_word(CMD_LOAD, 64'd2, 32'h5A5A_A5A5);
		send_word(CMD_LOOKUP, 64'd2, rand_count());
		send_word(CMD_CLEAR, rand64(), rand_count());
		send_word(CMD_LOOKUP, '0, rand_count());
	endtask

	// keys packed into a narrow span with many duplicates, build below the fill threshold
	task automatic test_dense_keys();
		send_word(CMD_CLEAR, rand64(), rand_count());
		load_sorted(400 + $urandom_range(0, 50), rand64() >> 1, 1, 14);
		send_word(CMD_BUILD, rand64(), rand_count());
		probe_lookups(200);
		wait_for_idle();
	endtask

	// wide key span from zero to all ones, builds on a small table, loads after build
	task automatic test_wide_keys();
		send_word(CMD_CLEAR, rand64(), rand_count());
		load_sorted(300, '0, 50, 1);
		send_word(CMD_BUILD, rand64(), rand_count());
		probe_lookups(20);
		send_word(CMD_LOAD, '1, '1);
		send_word(CMD_BUILD, rand64(), rand_count());
		probe_lookups(100);
		send_word(CMD_LOAD, '1, rand_count());
		probe_lookups(20);
	endtask

	// random key order, whole-table search over unsorted entries
	task automatic test_unsorted_keys();
		send_word(CMD_CLEAR, rand64(), rand_count());
		repeat (150 + $urandom_range(0, 20))
			send_word(CMD_LOAD, rand64(), rand_count());
		send_word(CMD_BUILD, rand64(), rand_count());
		probe_lookups(100);
	endtask

	// mostly lookups and ascending loads, rare builds and clears
	task automatic test_random_mix(int unsigned n);
		int unsigned      sel;
		logic [KEY_W-1:0] k;
		repeat (n) begin
			sel = $urandom_range(0, 255);
			if (sel == 0) begin
				send_word(CMD_CLEAR, rand64(), rand_count());
			end else if (sel < 3) begin
				send_word(CMD_BUILD, rand64(), rand_count());
			end else if (sel < 60) begin
				if (table_fill != 0 && $urandom_range(0, 7) != 0)
					k = table_keys[table_fill-1] + $urandom_range(0, 3000);
				else
					k = rand64();
				send_word(CMD_LOAD, k, rand_count());
			end else begin
				send_word(CMD_LOOKUP, pick_probe_key(), rand_count());
			end
		end
	endtask

	// receiver stall pattern: free, light and heavy stretches
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(8, 160);
		end
		stall_left--;
		case (stall_mode)
			0:       rsp_stall <= 1'b0;
			1:       rsp_stall <= ($urandom_range(0, 3) == 0);
			default: rsp_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// compare each accepted rsp word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (owed_rsp.size() == 0) begin
				$display("%0t unexpected rsp word: status %0d found_count %0h",
					$time, rsp.status, rsp.found_count);
				errors++;
			end else begin
				oldest_rsp = owed_rsp.pop_front();
				if (rsp.status !== oldest_rsp.status) begin
					$display("%0t status mismatch: expected %0d actual %0d",
						$time, oldest_rsp.status, rsp.status);
					errors++;
				end
				if (rsp.found_count !== oldest_rsp.found_count) begin
					$display("%0t found_count mismatch: expected %0h actual %0h",
						$time, oldest_rsp.found_count, rsp.found_count);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no accept on either channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// reset, tests in turn, drain, verdict
	initial begin
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		rsp_stall  = 1'b0;
		errors     = 0;
		burst_left = 0;
		table_fill = 0;
		key_shift  = 0;
		index_ok   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_small_table();
		test_dense_keys();
		test_wide_keys();
		test_unsorted_keys();
		test_random_mix(500);
		wait_for_idle();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
